>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> hw/rtl/pls_pkg.sv
// Shared types and constants of the polyline length splitter.
`timescale 1ns / 1ps
package pls_pkg;
    localparam int LEN_BITS  = 48;
    localparam int DIST_BITS = 40;
    localparam int CNT_BITS  = 16;
    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;
    localparam logic [CNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [DIST_BITS-1:0] DIST_RESET = 40'd65536;

    typedef enum logic [1:0] {
        KIND_VERTEX  = 2'd0,
        KIND_BREAK   = 2'd1,
        KIND_SUMMARY = 2'd2
    } kind_t;

    // Classification passed from front to back.
    typedef enum logic [1:0] {
        CLS_DUP    = 2'd0,
        CLS_FIRST  = 2'd1,
        CLS_SECOND = 2'd2,
        CLS_MORE   = 2'd3
    } cls_t;
endpackage

>>> hw/rtl/polyline_length_splitter_core.sv
// Top level of the polyline length splitter.
//   channel   | handshake            | payload
//   config    | cfg_valid/cfg_ready  | cfg_data (split distance)
//   input     | in_valid/in_stall    | coord_x, coord_y, coord_z, line_end
//   output    | out_valid/out_stall  | kind, out_x, out_y, out_z, split_total, last
// The back end takes the queue entry, runs CB+1 square-root steps, accumulates and emits
// a vertex. A break and a line summary add a state each; a first vertex skips the root
// and accumulation, and a duplicate emits only a summary at a line end. The front end
// steps through take, square-x, square-y and push and prepares the next vertex meanwhile.
// Reset clears the line state and sets the split distance to 65536. A stalled output
// holds the back end; the input stalls whenever the front end is busy.
`timescale 1ns / 1ps
module polyline_length_splitter_core #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [39:0]                  cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    input  logic signed [COORD_BITS-1:0] coord_z,
    input  logic                         line_end,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   kind,
    output logic signed [COORD_BITS-1:0] out_x,
    output logic signed [COORD_BITS-1:0] out_y,
    output logic signed [COORD_BITS-1:0] out_z,
    output logic [15:0]                  split_total,
    output logic                         last
);
    localparam int CB = COORD_BITS + 0 * FRAC_BITS;
    localparam int SW = 2 * CB + 2;

    logic [pls_pkg::DIST_BITS-1:0] dist_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dist_reg <= pls_pkg::DIST_RESET;
        else if (cfg_valid)
            dist_reg <= cfg_data;
    end

    // one-entry queue between front and back
    logic          pv, qf, pop, qv_reg;
    pls_pkg::cls_t pc, qc_reg;
    logic [SW-1:0] ps, qs_reg;
    logic [CB-1:0] px, py, pz, ppx, ppy, ppz;
    logic [CB-1:0] qx_reg, qy_reg, qz_reg, qpx_reg, qpy_reg, qpz_reg;
    logic          pe, qe_reg;
    assign qf = qv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            qv_reg <= 1'b0;
        else if (pv && !qf)
            qv_reg <= 1'b1;
        else if (pop)
            qv_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pv && !qf)
        begin
            qc_reg <= pc;
            qs_reg <= ps;
            qx_reg <= px;
            qy_reg <= py;
            qz_reg <= pz;
            qpx_reg <= ppx;
            qpy_reg <= ppy;
            qpz_reg <= ppz;
            qe_reg <= pe;
        end
    end

    pls_front #(.CB(CB)) u_front (
        .clk, .rst_n, .in_valid, .in_stall,
        .cx(coord_x), .cy(coord_y), .cz(coord_z), .lend(line_end),
        .q_valid(pv), .q_full(qf), .q_cls(pc), .q_sum(ps),
        .q_x(px), .q_y(py), .q_z(pz), .q_px(ppx), .q_py(ppy), .q_pz(ppz), .q_end(pe)
    );

    // the back end pops on entry but reads the entry until done, so keep a copy
    logic [CB-1:0] bx_reg, by_reg, bz_reg, bpx_reg, bpy_reg, bpz_reg;
    pls_pkg::cls_t bc_reg;
    logic          be_reg;
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            bx_reg <= qx_reg; by_reg <= qy_reg; bz_reg <= qz_reg;
            bpx_reg <= qpx_reg; bpy_reg <= qpy_reg; bpz_reg <= qpz_reg;
            bc_reg <= qc_reg; be_reg <= qe_reg;
        end
    end

    logic          e_valid;
    pls_pkg::cls_t e_cls;
    assign e_valid = qv_reg;
    assign e_cls   = pop ? qc_reg : bc_reg;

    pls_back #(.CB(CB)) u_back (
        .clk, .rst_n, .split_dist(dist_reg),
        .e_valid, .e_pop(pop), .e_cls,
        .e_sum(qs_reg),
        .e_x(bx_reg), .e_y(by_reg), .e_z(bz_reg),
        .e_px(bpx_reg), .e_py(bpy_reg), .e_pz(bpz_reg),
        .e_end(pop ? qe_reg : be_reg),
        .out_valid, .out_stall, .kind, .out_x, .out_y, .out_z, .split_total, .last
    );
endmodule

>>> hw/rtl/pls_front.sv
// Front end: duplicate test, square sum of the x and y differences, classification.
`timescale 1ns / 1ps
module pls_front #(
    parameter int CB = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [CB-1:0] cx,
    input  logic signed [CB-1:0] cy,
    input  logic signed [CB-1:0] cz,
    input  logic                 lend,
    // queue push
    output logic                 q_valid,
    input  logic                 q_full,
    output pls_pkg::cls_t        q_cls,
    output logic [2*CB+1:0]      q_sum,
    output logic [CB-1:0]        q_x,
    output logic [CB-1:0]        q_y,
    output logic [CB-1:0]        q_z,
    output logic [CB-1:0]        q_px,
    output logic [CB-1:0]        q_py,
    output logic [CB-1:0]        q_pz,
    output logic                 q_end
);
    typedef enum logic [1:0] { F_IDLE, F_SQX, F_SQY, F_PUSH } fst_t;
    localparam int SW = 2 * CB + 2;

    fst_t           st_reg;
    logic [CB-1:0]  px_reg, py_reg, pz_reg, x_reg, y_reg, z_reg;
    logic [1:0]     kept_reg;
    logic           end_reg;
    pls_pkg::cls_t  cls_reg;
    logic [CB:0]    dx_reg, dy_reg;
    logic [SW-1:0]  sum_reg;

    // absolute differences at CB+1 bits
    logic signed [CB:0] dxs, dys;
    logic [2*CB+1:0]    sq;
    logic               dup;
    assign dxs = {cx[CB-1], cx} - {px_reg[CB-1], px_reg};
    assign dys = {cy[CB-1], cy} - {py_reg[CB-1], py_reg};
    assign dup = (kept_reg != 2'd0) && cx == px_reg && cy == py_reg && cz == pz_reg;
    assign sq  = (st_reg == F_SQX) ? dx_reg * dx_reg : dy_reg * dy_reg;

    assign in_stall = (st_reg != F_IDLE);
    assign q_valid  = (st_reg == F_PUSH);
    assign q_cls = cls_reg;
    assign q_sum = sum_reg;
    assign q_x = x_reg;
    assign q_y = y_reg;
    assign q_z = z_reg;
    assign q_end = end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= F_IDLE;
            kept_reg <= 2'd0;
            px_reg <= '0;
            py_reg <= '0;
            pz_reg <= '0;
        end
        else
        begin
            unique case (st_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        x_reg <= cx;
                        y_reg <= cy;
                        z_reg <= cz;
                        end_reg <= lend;
                        q_px <= px_reg;
                        q_py <= py_reg;
                        q_pz <= pz_reg;
                        dx_reg <= dxs[CB] ? (CB+1)'(-dxs) : dxs;
                        dy_reg <= dys[CB] ? (CB+1)'(-dys) : dys;
                        sum_reg <= '0;
                        if (dup)
                            cls_reg <= pls_pkg::CLS_DUP;
                        else if (kept_reg == 2'd0)
                            cls_reg <= pls_pkg::CLS_FIRST;
                        else if (kept_reg == 2'd1)
                            cls_reg <= pls_pkg::CLS_SECOND;
                        else
                            cls_reg <= pls_pkg::CLS_MORE;
                        // track the line state here
                        if (lend)
                        begin
                            kept_reg <= 2'd0;
                            px_reg <= '0;
                            py_reg <= '0;
                            pz_reg <= '0;
                        end
                        else if (!dup)
                        begin
                            kept_reg <= (kept_reg == 2'd0) ? 2'd1 : 2'd2;
                            px_reg <= cx;
                            py_reg <= cy;
                            pz_reg <= cz;
                        end
                        st_reg <= F_SQX;
                    end
                end
                F_SQX:
                begin
                    sum_reg <= sq;
                    st_reg <= F_SQY;
                end
                F_SQY:
                begin
                    sum_reg <= sum_reg + sq;
                    st_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (!q_full)
                        st_reg <= F_IDLE;
                end
                default: st_reg <= F_IDLE;
            endcase
        end
    end
endmodule

>>> hw/rtl/pls_back.sv
// Back end: bit-serial square root, length accumulation, result emission.
`timescale 1ns / 1ps
module pls_back #(
    parameter int CB = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [pls_pkg::DIST_BITS-1:0] split_dist,
    input  logic                 e_valid,
    output logic                 e_pop,
    input  pls_pkg::cls_t        e_cls,
    input  logic [2*CB+1:0]      e_sum,
    input  logic [CB-1:0]        e_x,
    input  logic [CB-1:0]        e_y,
    input  logic [CB-1:0]        e_z,
    input  logic [CB-1:0]        e_px,
    input  logic [CB-1:0]        e_py,
    input  logic [CB-1:0]        e_pz,
    input  logic                 e_end,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           kind,
    output logic [CB-1:0]        out_x,
    output logic [CB-1:0]        out_y,
    output logic [CB-1:0]        out_z,
    output logic [15:0]          split_total,
    output logic                 last
);
    typedef enum logic [2:0] { B_IDLE, B_ROOT, B_ACC, B_BRK, B_VTX, B_SUM } bst_t;
    localparam int SW = 2 * CB + 2;
    localparam int RW = CB + 1;
    localparam int IW = $clog2(RW + 1);
    localparam int LB = pls_pkg::LEN_BITS;

    bst_t          st_reg;
    logic [SW-1:0] rem_reg;
    logic [RW-1:0] root_reg;
    logic [IW-1:0] it_reg;
    logic [LB-1:0] run_reg;
    logic [15:0]   cnt_reg;

    // restoring square root, one result bit per cycle
    logic [RW+1:0] trial;
    logic [RW+1:0] rhi;
    logic [SW-1:0] rem_sh;
    logic [RW-1:0] root_sh;
    logic [LB-1:0] seg_sat;
    logic [LB:0]   sum_run;
    logic [LB-1:0] run_sat;
    logic          over;
    logic [15:0]   cnt_inc;
    always_comb
    begin
        rem_sh  = rem_reg;
        root_sh = root_reg;
        rhi = (RW+2)'(rem_reg >> (2 * (int'(it_reg) - 1)));
        trial = {root_reg, 2'b01};
        if (RW > LB)
            seg_sat = (root_reg >> LB) != '0 ? pls_pkg::LEN_MAX : LB'(root_reg);
        else
            seg_sat = LB'(root_reg);
        sum_run = {1'b0, run_reg} + {1'b0, seg_sat};
        run_sat = sum_run[LB] ? pls_pkg::LEN_MAX : sum_run[LB-1:0];
        over = run_sat > {{(LB - pls_pkg::DIST_BITS){1'b0}}, split_dist};
        cnt_inc = (cnt_reg == pls_pkg::CNT_MAX) ? cnt_reg : cnt_reg + 16'd1;
        if (rhi >= trial)
        begin
            rem_sh  = rem_reg - (SW'(trial) << (2 * (int'(it_reg) - 1)));
            root_sh = {root_reg[RW-2:0], 1'b1};
        end
        else
            root_sh = {root_reg[RW-2:0], 1'b0};
    end

    logic out_free;
    logic emit;
    assign out_free = !out_valid || !out_stall;
    assign emit = out_free && (st_reg == B_BRK || st_reg == B_VTX || st_reg == B_SUM);
    assign e_pop = (st_reg == B_IDLE) && e_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= B_IDLE;
            out_valid <= 1'b0;
            run_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (emit)
                out_valid <= 1'b1;
            else if (!out_stall)
                out_valid <= 1'b0;
            unique case (st_reg)
                B_IDLE:
                begin
                    if (e_valid)
                    begin
                        rem_reg  <= e_sum;
                        root_reg <= '0;
                        it_reg   <= IW'(RW);
                        unique case (e_cls)
                            pls_pkg::CLS_DUP:    st_reg <= e_end ? B_SUM : B_IDLE;
                            pls_pkg::CLS_FIRST:
                            begin
                                run_reg <= '0;
                                st_reg  <= B_VTX;
                            end
                            default:             st_reg <= B_ROOT;
                        endcase
                    end
                end
                B_ROOT:
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= root_sh;
                    it_reg   <= it_reg - 1'b1;
                    if (it_reg == IW'(1))
                        st_reg <= B_ACC;
                end
                // accumulate and decide on a break
                B_ACC:
                begin
                    if (e_cls == pls_pkg::CLS_SECOND)
                    begin
                        run_reg <= seg_sat;
                        st_reg  <= B_VTX;
                    end
                    else if (over)
                    begin
                        run_reg <= seg_sat;
                        st_reg  <= B_BRK;
                    end
                    else
                    begin
                        run_reg <= run_sat;
                        st_reg  <= B_VTX;
                    end
                end
                B_BRK:
                begin
                    if (out_free)
                    begin
                        kind  <= pls_pkg::KIND_BREAK;
                        out_x <= e_px;
                        out_y <= e_py;
                        out_z <= e_pz;
                        split_total <= cnt_inc;
                        cnt_reg <= cnt_inc;
                        last <= 1'b0;
                        st_reg <= B_VTX;
                    end
                end
                B_VTX:
                begin
                    if (out_free)
                    begin
                        kind  <= pls_pkg::KIND_VERTEX;
                        out_x <= e_x;
                        out_y <= e_y;
                        out_z <= e_z;
                        split_total <= cnt_reg;
                        last  <= !e_end;
                        st_reg <= e_end ? B_SUM : B_IDLE;
                    end
                end
                B_SUM:
                begin
                    if (out_free)
                    begin
                        kind  <= pls_pkg::KIND_SUMMARY;
                        out_x <= '0;
                        out_y <= '0;
                        out_z <= '0;
                        split_total <= cnt_reg;
                        last <= 1'b1;
                        cnt_reg <= '0;
                        run_reg <= '0;
                        st_reg <= B_IDLE;
                    end
                end
                default: st_reg <= B_IDLE;
            endcase
        end
    end
endmodule

>>> hw/rtl/pls_checker.sv
// Port-level checker for the polyline length splitter, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pls_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  kind,
    input logic        last,
    input logic [15:0] split_total
);
    `CHK_IMPLY(a_sum_last, clk, rst_n, out_valid && kind == pls_pkg::KIND_SUMMARY, last, "summary not last")
    `CHK_IMPLY(a_brk_cnt, clk, rst_n, out_valid && kind == pls_pkg::KIND_BREAK, split_total != 16'd0, "break with zero count")
    `CHK_IMPLY(a_brk_last, clk, rst_n, out_valid && kind == pls_pkg::KIND_BREAK, !last, "break marked last")
    `CHK_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(kind), "stalled result changed")
endmodule

bind polyline_length_splitter_core pls_checker u_chk (
    .clk, .rst_n, .out_valid, .out_stall, .kind, .last, .split_total
);
